>>> design/rcd_pkg.sv
// ----------------------------------------------------------------------------
// Rotation-compensated disparity package
// Shared widths, register indexes, datapath commands and status for the
// rotation-compensated disparity unit.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int PIX_W      = 16;
    localparam int ROT_W      = 16;
    localparam int ROT_ROW_W  = 3 * ROT_W;
    localparam int PAIR_W     = 2 * PIX_W;
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = ROT_ROW_W;
    localparam int MAX_POINTS = 4096;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SUM_W      = 32;
    localparam int DIST_W     = 20;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam int NORM_FRAC  = 16;
    localparam int NORM_BIT   = 24;
    localparam int NORM_W     = NORM_BIT + 1;
    localparam int XW         = 44;
    localparam int MA_W       = 21;
    localparam int MB_W       = XW;
    localparam int PW         = MA_W + MB_W;
    localparam int DIV_NW     = 60;
    localparam int DIV_DW     = XW;
    localparam int DIV_CW     = $clog2(DIV_NW);
    localparam int DIFF_W     = DIV_NW + 2;
    localparam int DU_BIT     = 20;
    localparam int DU_W       = DU_BIT + 1;
    localparam int SQ_W       = 42;
    localparam int ROOT_W     = SQ_W / 2 + 1;

    localparam logic [PAIR_W-1:0]    FOCAL_RST  = 32'h0010_0010;
    localparam logic [PAIR_W-1:0]    CENTER_RST = '0;
    localparam logic [ROT_ROW_W-1:0] ROT0_RST   = 48'h4000_0000_0000;
    localparam logic [ROT_ROW_W-1:0] ROT1_RST   = 48'h0000_4000_0000;
    localparam logic [ROT_ROW_W-1:0] ROT2_RST   = 48'h0000_0000_4000;

    typedef enum logic [CFG_IW-1:0] {
        REG_FOCAL  = 3'd0,
        REG_CENTER = 3'd1,
        REG_ROT0   = 3'd2,
        REG_ROT1   = 3'd3,
        REG_ROT2   = 3'd4
    } reg_index_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIV_A, OP_DIV_B, OP_TAKE_B,
        OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6,
        OP_DIV_X, OP_DIV_Y, OP_TAKE_Y, OP_DIFF,
        OP_SQ0, OP_SQ1, OP_SQ2, OP_TAKE_R,
        OP_SAT, OP_ACC, OP_MEAN, OP_TAKE_M, OP_EMIT
    } op_t;

    typedef struct packed {
        logic full;
        logic fx_zero;
        logic ab_wide;
        logic z_bad;
        logic d_wide;
        logic div_done;
        logic sqrt_done;
        logic last;
        logic out_free;
    } status_t;

    function automatic logic signed [ROT_W-1:0] rot_at(input logic [ROT_ROW_W-1:0] row,
                                                       input logic [1:0] col);
        logic signed [ROT_W-1:0] entry;
        case (col)
            2'd0:    entry = signed'(row[3*ROT_W-1:2*ROT_W]);
            2'd1:    entry = signed'(row[2*ROT_W-1:ROT_W]);
            default: entry = signed'(row[ROT_W-1:0]);
        endcase
        return entry;
    endfunction

endpackage

>>> design/rcd_in_if.sv
// ----------------------------------------------------------------------------
// Pair input channel
// Valid/ready channel that carries one matched point pair per item.
// ----------------------------------------------------------------------------
interface rcd_in_if;
    logic                      valid;
    logic                      ready;
    logic [rcd_pkg::PIX_W-1:0] current_u;
    logic [rcd_pkg::PIX_W-1:0] current_v;
    logic [rcd_pkg::PIX_W-1:0] keyframe_u;
    logic [rcd_pkg::PIX_W-1:0] keyframe_v;
    logic                      last_pair;

    modport source(output valid, current_u, current_v, keyframe_u, keyframe_v, last_pair,
                   input ready);
    modport sink(input valid, current_u, current_v, keyframe_u, keyframe_v, last_pair,
                 output ready);
endinterface

>>> design/rcd_out_if.sv
// ----------------------------------------------------------------------------
// Mean disparity output channel
// Valid/ready channel that carries one set result per item.
// ----------------------------------------------------------------------------
interface rcd_out_if;
    logic                       valid;
    logic                       ready;
    logic [rcd_pkg::DIST_W-1:0] mean_disparity;
    logic [rcd_pkg::CNT_W-1:0]  pair_count;
    logic                       any_saturated;

    modport source(output valid, mean_disparity, pair_count, any_saturated, input ready);
    modport sink(input valid, mean_disparity, pair_count, any_saturated, output ready);
endinterface

>>> design/rcd_div.sv
// ----------------------------------------------------------------------------
// Shared iterative divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rcd_pkg::DIV_NW-1:0]  dividend,
    input  logic [rcd_pkg::DIV_DW-1:0]  divisor,
    output logic                        done,
    output logic [rcd_pkg::DIV_NW-1:0]  quotient
);
    logic [rcd_pkg::DIV_NW-1:0] q_reg;
    logic [rcd_pkg::DIV_DW-1:0] rem_reg;
    logic [rcd_pkg::DIV_DW-1:0] dvs_reg;
    logic [rcd_pkg::DIV_CW-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [rcd_pkg::DIV_DW:0]   rem_sh;
    logic [rcd_pkg::DIV_DW:0]   rem_sub;
    logic                       fits;

    assign rem_sh  = {rem_reg, q_reg[rcd_pkg::DIV_NW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rcd_pkg::DIV_CW'(rcd_pkg::DIV_NW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[rcd_pkg::DIV_NW-2:0], fits};
            rem_reg <= fits ? rem_sub[rcd_pkg::DIV_DW-1:0] : rem_sh[rcd_pkg::DIV_DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

>>> design/rcd_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative square root
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module rcd_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rcd_pkg::SQ_W-1:0]    radicand,
    output logic                        done,
    output logic [rcd_pkg::ROOT_W-1:0]  root
);
    logic [rcd_pkg::SQ_W-1:0] n_reg;
    logic [rcd_pkg::SQ_W-1:0] r_reg;
    logic [rcd_pkg::SQ_W-1:0] bit_reg;
    logic                     done_reg;
    logic [rcd_pkg::SQ_W-1:0] trial;
    logic                     take;

    assign trial = r_reg + bit_reg;
    assign take  = n_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (bit_reg == rcd_pkg::SQ_W'(1));
            if (start)
            begin
                bit_reg <= rcd_pkg::SQ_W'(1) << (rcd_pkg::SQ_W - 2);
            end
            else
            begin
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= radicand;
            r_reg <= '0;
        end
        else if (bit_reg != '0)
        begin
            if (take)
            begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[rcd_pkg::ROOT_W-1:0] + rcd_pkg::ROOT_W'(n_reg > r_reg);
endmodule

>>> design/rcd_datapath.sv
// ----------------------------------------------------------------------------
// Disparity datapath
// Configuration registers, shared multiplier, divider and square root, and
// the running sum, count and output register.
// ----------------------------------------------------------------------------
module rcd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcd_pkg::op_t                  cmd,
    output rcd_pkg::status_t              status,
    input  logic                          cfg_we,
    input  logic [rcd_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [rcd_pkg::CFG_DW-1:0]    cfg_data,
    input  logic [rcd_pkg::PIX_W-1:0]     current_u,
    input  logic [rcd_pkg::PIX_W-1:0]     current_v,
    input  logic [rcd_pkg::PIX_W-1:0]     keyframe_u,
    input  logic [rcd_pkg::PIX_W-1:0]     keyframe_v,
    input  logic                          last_pair,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [rcd_pkg::DIST_W-1:0]    mean_disparity,
    output logic [rcd_pkg::CNT_W-1:0]     pair_count,
    output logic                          any_saturated
);
    localparam logic signed [rcd_pkg::DIFF_W-1:0] DU_LIM =
        rcd_pkg::DIFF_W'(1) << rcd_pkg::DU_BIT;

    logic [rcd_pkg::PAIR_W-1:0]     focal_reg;
    logic [rcd_pkg::PAIR_W-1:0]     center_reg;
    logic [rcd_pkg::ROT_ROW_W-1:0]  rot0_reg;
    logic [rcd_pkg::ROT_ROW_W-1:0]  rot1_reg;
    logic [rcd_pkg::ROT_ROW_W-1:0]  rot2_reg;

    logic [rcd_pkg::PIX_W-1:0]      cu_reg;
    logic [rcd_pkg::PIX_W-1:0]      cv_reg;
    logic [rcd_pkg::PIX_W-1:0]      ku_reg;
    logic [rcd_pkg::PIX_W-1:0]      kv_reg;
    logic                           last_reg;

    logic signed [rcd_pkg::NORM_W-1:0] a_reg;
    logic signed [rcd_pkg::NORM_W-1:0] b_reg;
    logic                              ab_wide_reg;
    logic signed [rcd_pkg::PW-1:0]     prod_reg;
    logic signed [rcd_pkg::XW-1:0]     acc_reg;
    logic signed [rcd_pkg::XW-1:0]     x_reg;
    logic signed [rcd_pkg::XW-1:0]     y_reg;
    logic signed [rcd_pkg::XW-1:0]     z_reg;
    logic signed [rcd_pkg::DIV_NW:0]   qx_reg;
    logic signed [rcd_pkg::DIV_NW:0]   qy_reg;
    logic signed [rcd_pkg::DU_W-1:0]   du_reg;
    logic signed [rcd_pkg::DU_W-1:0]   dv_reg;
    logic                              d_wide_reg;
    logic [rcd_pkg::SQ_W-1:0]          sq_reg;
    logic [rcd_pkg::DIST_W-1:0]        dist_reg;
    logic                              psat_reg;
    logic                              div_neg_reg;
    logic [rcd_pkg::DIST_W-1:0]        mean_reg;

    logic [rcd_pkg::SUM_W-1:0]         sum_reg;
    logic [rcd_pkg::CNT_W-1:0]         cnt_reg;
    logic                              seen_reg;
    logic                              out_valid_reg;
    logic [rcd_pkg::DIST_W-1:0]        out_mean_reg;
    logic [rcd_pkg::CNT_W-1:0]         out_cnt_reg;
    logic                              out_sat_reg;

    logic [rcd_pkg::PIX_W-1:0]         fx;
    logic [rcd_pkg::PIX_W-1:0]         fy;
    logic [rcd_pkg::PIX_W-1:0]         cx;
    logic [rcd_pkg::PIX_W-1:0]         cy;
    logic signed [rcd_pkg::PIX_W:0]    diff_u;
    logic signed [rcd_pkg::PIX_W:0]    diff_v;
    logic signed [rcd_pkg::PIX_W:0]    neg_u;
    logic signed [rcd_pkg::PIX_W:0]    neg_v;
    logic [rcd_pkg::PIX_W-1:0]         mag_u;
    logic [rcd_pkg::PIX_W-1:0]         mag_v;
    logic signed [rcd_pkg::PW-1:0]     prod_abs;
    logic                              div_start;
    logic                              div_neg;
    logic [rcd_pkg::DIV_NW-1:0]        div_dvd;
    logic [rcd_pkg::DIV_DW-1:0]        div_dvs;
    logic                              div_done;
    logic [rcd_pkg::DIV_NW-1:0]        div_q;
    logic signed [rcd_pkg::DIV_NW:0]   q_signed;
    logic                              q_wide;
    logic signed [rcd_pkg::MA_W-1:0]   ma;
    logic signed [rcd_pkg::MB_W-1:0]   mb;
    logic signed [rcd_pkg::DIFF_W-1:0] du_full;
    logic signed [rcd_pkg::DIFF_W-1:0] dv_full;
    logic                              sqrt_done;
    logic [rcd_pkg::ROOT_W-1:0]        root;
    logic [rcd_pkg::CNT_W-1:0]         count_n;
    logic [rcd_pkg::SUM_W:0]           mean_dvd;
    logic [rcd_pkg::SUM_W:0]           sum_ext;

    assign fx = focal_reg[rcd_pkg::PAIR_W-1:rcd_pkg::PIX_W];
    assign fy = focal_reg[rcd_pkg::PIX_W-1:0];
    assign cx = center_reg[rcd_pkg::PAIR_W-1:rcd_pkg::PIX_W];
    assign cy = center_reg[rcd_pkg::PIX_W-1:0];

    assign diff_u = signed'({1'b0, cu_reg}) - signed'({1'b0, cx});
    assign diff_v = signed'({1'b0, cv_reg}) - signed'({1'b0, cy});
    assign neg_u  = -diff_u;
    assign neg_v  = -diff_v;
    assign mag_u  = diff_u[rcd_pkg::PIX_W] ? neg_u[rcd_pkg::PIX_W-1:0] : diff_u[rcd_pkg::PIX_W-1:0];
    assign mag_v  = diff_v[rcd_pkg::PIX_W] ? neg_v[rcd_pkg::PIX_W-1:0] : diff_v[rcd_pkg::PIX_W-1:0];
    assign prod_abs = prod_reg[rcd_pkg::PW-1] ? -prod_reg : prod_reg;

    assign q_signed = div_neg_reg ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
    assign q_wide   = |div_q[rcd_pkg::DIV_NW-1:rcd_pkg::NORM_BIT];

    assign du_full = rcd_pkg::DIFF_W'(signed'({1'b0, ku_reg}))
                   - rcd_pkg::DIFF_W'(signed'({1'b0, cx})) - rcd_pkg::DIFF_W'(qx_reg);
    assign dv_full = rcd_pkg::DIFF_W'(signed'({1'b0, kv_reg}))
                   - rcd_pkg::DIFF_W'(signed'({1'b0, cy})) - rcd_pkg::DIFF_W'(qy_reg);

    assign count_n  = (cnt_reg == '0) ? rcd_pkg::CNT_W'(1) : cnt_reg;
    assign mean_dvd = {1'b0, sum_reg} + (rcd_pkg::SUM_W + 1)'(count_n >> 1);
    assign sum_ext  = {1'b0, sum_reg} + (rcd_pkg::SUM_W + 1)'(dist_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_neg   = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (cmd)
            rcd_pkg::OP_DIV_A:
            begin
                div_start = 1'b1;
                div_neg   = diff_u[rcd_pkg::PIX_W];
                div_dvd   = rcd_pkg::DIV_NW'({mag_u, {rcd_pkg::NORM_FRAC{1'b0}}});
                div_dvs   = rcd_pkg::DIV_DW'(fx);
            end
            rcd_pkg::OP_DIV_B:
            begin
                div_start = 1'b1;
                div_neg   = diff_v[rcd_pkg::PIX_W];
                div_dvd   = rcd_pkg::DIV_NW'({mag_v, {rcd_pkg::NORM_FRAC{1'b0}}});
                div_dvs   = rcd_pkg::DIV_DW'(fy);
            end
            rcd_pkg::OP_DIV_X, rcd_pkg::OP_DIV_Y:
            begin
                div_start = 1'b1;
                div_neg   = prod_reg[rcd_pkg::PW-1];
                div_dvd   = prod_abs[rcd_pkg::DIV_NW-1:0];
                div_dvs   = $unsigned(z_reg);
            end
            rcd_pkg::OP_MEAN:
            begin
                div_start = 1'b1;
                div_dvd   = rcd_pkg::DIV_NW'(mean_dvd);
                div_dvs   = rcd_pkg::DIV_DW'(count_n);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd)
            rcd_pkg::OP_M0:
            begin
                ma = rcd_pkg::MA_W'(rcd_pkg::rot_at(rot0_reg, 2'd0));
                mb = rcd_pkg::MB_W'(a_reg);
            end
            rcd_pkg::OP_M1:
            begin
                ma = rcd_pkg::MA_W'(rcd_pkg::rot_at(rot0_reg, 2'd1));
                mb = rcd_pkg::MB_W'(b_reg);
            end
            rcd_pkg::OP_M2:
            begin
                ma = rcd_pkg::MA_W'(rcd_pkg::rot_at(rot1_reg, 2'd0));
                mb = rcd_pkg::MB_W'(a_reg);
            end
            rcd_pkg::OP_M3:
            begin
                ma = rcd_pkg::MA_W'(rcd_pkg::rot_at(rot1_reg, 2'd1));
                mb = rcd_pkg::MB_W'(b_reg);
            end
            rcd_pkg::OP_M4:
            begin
                ma = rcd_pkg::MA_W'(rcd_pkg::rot_at(rot2_reg, 2'd0));
                mb = rcd_pkg::MB_W'(a_reg);
            end
            rcd_pkg::OP_M5:
            begin
                ma = rcd_pkg::MA_W'(rcd_pkg::rot_at(rot2_reg, 2'd1));
                mb = rcd_pkg::MB_W'(b_reg);
            end
            rcd_pkg::OP_M6:
            begin
                ma = signed'(rcd_pkg::MA_W'(fx));
                mb = x_reg;
            end
            rcd_pkg::OP_DIV_X:
            begin
                ma = signed'(rcd_pkg::MA_W'(fy));
                mb = y_reg;
            end
            rcd_pkg::OP_SQ0:
            begin
                ma = du_reg;
                mb = rcd_pkg::MB_W'(du_reg);
            end
            rcd_pkg::OP_SQ1:
            begin
                ma = dv_reg;
                mb = rcd_pkg::MB_W'(dv_reg);
            end
            default:
            begin
                ma = '0;
            end
        endcase
    end

    rcd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    rcd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd == rcd_pkg::OP_SQ2),
        .radicand (sq_reg + prod_reg[rcd_pkg::SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= rcd_pkg::FOCAL_RST;
            center_reg <= rcd_pkg::CENTER_RST;
            rot0_reg   <= rcd_pkg::ROT0_RST;
            rot1_reg   <= rcd_pkg::ROT1_RST;
            rot2_reg   <= rcd_pkg::ROT2_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcd_pkg::REG_FOCAL:  focal_reg  <= cfg_data[rcd_pkg::PAIR_W-1:0];
                rcd_pkg::REG_CENTER: center_reg <= cfg_data[rcd_pkg::PAIR_W-1:0];
                rcd_pkg::REG_ROT0:   rot0_reg   <= cfg_data;
                rcd_pkg::REG_ROT1:   rot1_reg   <= cfg_data;
                rcd_pkg::REG_ROT2:   rot2_reg   <= cfg_data;
                default:             focal_reg  <= focal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                rcd_pkg::OP_ACC:
                begin
                    sum_reg  <= sum_ext[rcd_pkg::SUM_W] ? '1 : sum_ext[rcd_pkg::SUM_W-1:0];
                    cnt_reg  <= cnt_reg + 1'b1;
                    seen_reg <= seen_reg | psat_reg;
                end
                rcd_pkg::OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    sum_reg       <= '0;
                    cnt_reg       <= '0;
                    seen_reg      <= 1'b0;
                end
                default:
                begin
                    sum_reg <= sum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_neg_reg <= div_neg;
        end
        case (cmd)
            rcd_pkg::OP_LOAD:
            begin
                cu_reg   <= current_u;
                cv_reg   <= current_v;
                ku_reg   <= keyframe_u;
                kv_reg   <= keyframe_v;
                last_reg <= last_pair;
                psat_reg <= 1'b0;
            end
            rcd_pkg::OP_DIV_B:
            begin
                a_reg       <= q_signed[rcd_pkg::NORM_W-1:0];
                ab_wide_reg <= q_wide;
            end
            rcd_pkg::OP_TAKE_B:
            begin
                b_reg       <= q_signed[rcd_pkg::NORM_W-1:0];
                ab_wide_reg <= ab_wide_reg | q_wide;
            end
            rcd_pkg::OP_M0:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
            end
            rcd_pkg::OP_M1, rcd_pkg::OP_M3, rcd_pkg::OP_M5:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
                acc_reg  <= prod_reg[rcd_pkg::XW-1:0] + (rcd_pkg::XW'(rcd_pkg::rot_at(
                            (cmd == rcd_pkg::OP_M1) ? rot0_reg :
                            (cmd == rcd_pkg::OP_M3) ? rot1_reg : rot2_reg, 2'd2))
                            <<< rcd_pkg::NORM_FRAC);
            end
            rcd_pkg::OP_M2:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
                x_reg    <= acc_reg + prod_reg[rcd_pkg::XW-1:0];
            end
            rcd_pkg::OP_M4:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
                y_reg    <= acc_reg + prod_reg[rcd_pkg::XW-1:0];
            end
            rcd_pkg::OP_M6:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
                z_reg    <= acc_reg + prod_reg[rcd_pkg::XW-1:0];
            end
            rcd_pkg::OP_DIV_X:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
            end
            rcd_pkg::OP_DIV_Y:
            begin
                qx_reg <= q_signed;
            end
            rcd_pkg::OP_TAKE_Y:
            begin
                qy_reg <= q_signed;
            end
            rcd_pkg::OP_DIFF:
            begin
                du_reg     <= du_full[rcd_pkg::DU_W-1:0];
                dv_reg     <= dv_full[rcd_pkg::DU_W-1:0];
                d_wide_reg <= (du_full >= DU_LIM) || (du_full <= -DU_LIM)
                           || (dv_full >= DU_LIM) || (dv_full <= -DU_LIM);
            end
            rcd_pkg::OP_SQ0:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
            end
            rcd_pkg::OP_SQ1:
            begin
                prod_reg <= rcd_pkg::PW'(ma) * rcd_pkg::PW'(mb);
                sq_reg   <= prod_reg[rcd_pkg::SQ_W-1:0];
            end
            rcd_pkg::OP_TAKE_R:
            begin
                if (root > rcd_pkg::ROOT_W'(rcd_pkg::DIST_MAX))
                begin
                    dist_reg <= rcd_pkg::DIST_MAX;
                    psat_reg <= 1'b1;
                end
                else
                begin
                    dist_reg <= root[rcd_pkg::DIST_W-1:0];
                end
            end
            rcd_pkg::OP_SAT:
            begin
                dist_reg <= rcd_pkg::DIST_MAX;
                psat_reg <= 1'b1;
            end
            rcd_pkg::OP_TAKE_M:
            begin
                mean_reg <= (div_q > rcd_pkg::DIV_NW'(rcd_pkg::DIST_MAX)) ?
                            rcd_pkg::DIST_MAX : div_q[rcd_pkg::DIST_W-1:0];
            end
            rcd_pkg::OP_EMIT:
            begin
                out_mean_reg <= mean_reg;
                out_cnt_reg  <= cnt_reg;
                out_sat_reg  <= seen_reg;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign status.full      = cnt_reg >= rcd_pkg::CNT_W'(rcd_pkg::MAX_POINTS);
    assign status.fx_zero   = (fx == '0) || (fy == '0);
    assign status.ab_wide   = ab_wide_reg;
    assign status.z_bad     = z_reg[rcd_pkg::XW-1] || (z_reg == '0);
    assign status.d_wide    = d_wide_reg;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign mean_disparity = out_mean_reg;
    assign pair_count     = out_cnt_reg;
    assign any_saturated  = out_sat_reg;
endmodule

>>> design/rcd_ctrl.sv
// ----------------------------------------------------------------------------
// Disparity controller
// State machine that sequences one pair through the datapath and issues the
// set result on the last pair.
// ----------------------------------------------------------------------------
module rcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rcd_pkg::status_t  status,
    output rcd_pkg::op_t      cmd
);
    typedef enum logic [22:0] {
        ST_IDLE     = 23'd1 << 0,
        ST_CHECK    = 23'd1 << 1,
        ST_WAIT_A   = 23'd1 << 2,
        ST_WAIT_B   = 23'd1 << 3,
        ST_CHECK_AB = 23'd1 << 4,
        ST_M1       = 23'd1 << 5,
        ST_M2       = 23'd1 << 6,
        ST_M3       = 23'd1 << 7,
        ST_M4       = 23'd1 << 8,
        ST_M5       = 23'd1 << 9,
        ST_M6       = 23'd1 << 10,
        ST_CHECK_Z  = 23'd1 << 11,
        ST_WAIT_X   = 23'd1 << 12,
        ST_WAIT_Y   = 23'd1 << 13,
        ST_DIFF     = 23'd1 << 14,
        ST_CHECK_D  = 23'd1 << 15,
        ST_SQ1      = 23'd1 << 16,
        ST_SQ2      = 23'd1 << 17,
        ST_WAIT_R   = 23'd1 << 18,
        ST_ACC      = 23'd1 << 19,
        ST_TAIL     = 23'd1 << 20,
        ST_WAIT_M   = 23'd1 << 21,
        ST_EMIT     = 23'd1 << 22
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = rcd_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = rcd_pkg::OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.full)
                begin
                    state_next = ST_TAIL;
                end
                else if (status.fx_zero)
                begin
                    cmd        = rcd_pkg::OP_SAT;
                    state_next = ST_ACC;
                end
                else
                begin
                    cmd        = rcd_pkg::OP_DIV_A;
                    state_next = ST_WAIT_A;
                end
            end
            ST_WAIT_A:
            begin
                if (status.div_done)
                begin
                    cmd        = rcd_pkg::OP_DIV_B;
                    state_next = ST_WAIT_B;
                end
            end
            ST_WAIT_B:
            begin
                if (status.div_done)
                begin
                    cmd        = rcd_pkg::OP_TAKE_B;
                    state_next = ST_CHECK_AB;
                end
            end
            ST_CHECK_AB:
            begin
                if (status.ab_wide)
                begin
                    cmd        = rcd_pkg::OP_SAT;
                    state_next = ST_ACC;
                end
                else
                begin
                    cmd        = rcd_pkg::OP_M0;
                    state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                cmd        = rcd_pkg::OP_M1;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd        = rcd_pkg::OP_M2;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                cmd        = rcd_pkg::OP_M3;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                cmd        = rcd_pkg::OP_M4;
                state_next = ST_M5;
            end
            ST_M5:
            begin
                cmd        = rcd_pkg::OP_M5;
                state_next = ST_M6;
            end
            ST_M6:
            begin
                cmd        = rcd_pkg::OP_M6;
                state_next = ST_CHECK_Z;
            end
            ST_CHECK_Z:
            begin
                if (status.z_bad)
                begin
                    cmd        = rcd_pkg::OP_SAT;
                    state_next = ST_ACC;
                end
                else
                begin
                    cmd        = rcd_pkg::OP_DIV_X;
                    state_next = ST_WAIT_X;
                end
            end
            ST_WAIT_X:
            begin
                if (status.div_done)
                begin
                    cmd        = rcd_pkg::OP_DIV_Y;
                    state_next = ST_WAIT_Y;
                end
            end
            ST_WAIT_Y:
            begin
                if (status.div_done)
                begin
                    cmd        = rcd_pkg::OP_TAKE_Y;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd        = rcd_pkg::OP_DIFF;
                state_next = ST_CHECK_D;
            end
            ST_CHECK_D:
            begin
                if (status.d_wide)
                begin
                    cmd        = rcd_pkg::OP_SAT;
                    state_next = ST_ACC;
                end
                else
                begin
                    cmd        = rcd_pkg::OP_SQ0;
                    state_next = ST_SQ1;
                end
            end
            ST_SQ1:
            begin
                cmd        = rcd_pkg::OP_SQ1;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd        = rcd_pkg::OP_SQ2;
                state_next = ST_WAIT_R;
            end
            ST_WAIT_R:
            begin
                if (status.sqrt_done)
                begin
                    cmd        = rcd_pkg::OP_TAKE_R;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd        = rcd_pkg::OP_ACC;
                state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                if (status.last)
                begin
                    cmd        = rcd_pkg::OP_MEAN;
                    state_next = ST_WAIT_M;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT_M:
            begin
                if (status.div_done)
                begin
                    cmd        = rcd_pkg::OP_TAKE_M;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd        = rcd_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> design/rotation_compensated_disparity_unit.sv
// ----------------------------------------------------------------------------
// Rotation-compensated disparity unit
// One pair is in work at a time: a new item is accepted once the last pair is
// through, after four waits on the shared 60-step divider and a wait on the
// square root; a saturated pair finishes early. A last pair adds the mean
// divide, and its result item is made valid once the output register is free.
// Reset clears sum, count and flag; sets focal 16, center 0, identity rotation.
// ----------------------------------------------------------------------------
module rotation_compensated_disparity_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    rcd_in_if.sink                        in_ch,
    rcd_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [rcd_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [rcd_pkg::CFG_DW-1:0]    cfg_data
);
    rcd_pkg::status_t status;
    rcd_pkg::op_t     cmd;

    rcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rcd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .current_u      (in_ch.current_u),
        .current_v      (in_ch.current_v),
        .keyframe_u     (in_ch.keyframe_u),
        .keyframe_v     (in_ch.keyframe_v),
        .last_pair      (in_ch.last_pair),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .mean_disparity (out_ch.mean_disparity),
        .pair_count     (out_ch.pair_count),
        .any_saturated  (out_ch.any_saturated)
    );

    a_one_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("Second item accepted while a pair is in work.");

    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == rcd_pkg::OP_LOAD) |-> (in_ch.valid && in_ch.ready))
        else $error("Pair loaded without an accepted item.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.pair_count != '0)
            && (out_ch.pair_count <= rcd_pkg::CNT_W'(rcd_pkg::MAX_POINTS)))
        else $error("Result pair count out of range.");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == rcd_pkg::OP_EMIT) |-> (!out_ch.valid || out_ch.ready))
        else $error("Result overwritten before it was taken.");
endmodule

>>> bench/tb_rotation_compensated_disparity_unit.sv
// ----------------------------------------------------------------------------
// Rotation-compensated disparity unit testbench
// Sends matched point pairs under several camera and rotation settings,
// predicts the mean distance of every set in fixed point and compares each
// result item against it, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_rotation_compensated_disparity_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     SETTLE      = 450;
    localparam int     HOLD_CYCLES = 12000;

    typedef struct packed {
        logic [rcd_pkg::DIST_W-1:0] mean;
        logic [rcd_pkg::CNT_W-1:0]  count;
        logic                       sat;
    } set_result_t;

    typedef struct {
        logic [rcd_pkg::PIX_W-1:0] cu, cv, ku, kv;
        logic                      last;
        bit                        typed;
        set_result_t               res;
    } pair_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rcd_pkg::CFG_IW-1:0] cfg_index;
    logic [rcd_pkg::CFG_DW-1:0] cfg_data;

    rcd_in_if  in_ch();
    rcd_out_if out_ch();

    rotation_compensated_disparity_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    logic [rcd_pkg::PAIR_W-1:0]    focal_reg;
    logic [rcd_pkg::PAIR_W-1:0]    center_reg;
    logic [rcd_pkg::ROT_ROW_W-1:0] rot_reg [3];
    longint unsigned               dist_sum;
    int                            pairs_in_set;
    bit                            sat_in_set;

    set_result_t set_results [$];
    set_result_t typed_results [$];
    int  errors;
    int  sets_done;
    int  pairs_sent;
    int  sat_sets;
    bit  idle_on;
    bit  hold_req;
    bit  hold_done;
    int  holdoff;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("rotation_compensated_disparity_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("error at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    function automatic longint rot_of(input int r, input int c);
        logic [rcd_pkg::ROT_W-1:0] e;
        e = rot_reg[r][(2 - c) * rcd_pkg::ROT_W +: rcd_pkg::ROT_W];
        return longint'($signed(e));
    endfunction

    function automatic longint unsigned root_rounded(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 21; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        if (n - r * r > r)
            r++;
        return r;
    endfunction

    function automatic logic [rcd_pkg::DIST_W-1:0] pair_distance(
        input logic [rcd_pkg::PIX_W-1:0] cu, cv, ku, kv, output bit sat);
        longint fx, fy, cx, cy, a, b, x, y, z, du, dv;
        longint unsigned d;
        fx = focal_reg[31:16];
        fy = focal_reg[15:0];
        cx = center_reg[31:16];
        cy = center_reg[15:0];
        sat = 1'b1;
        if (fx == 0 || fy == 0)
            return rcd_pkg::DIST_MAX;
        a = ((longint'(cu) - cx) * 65536) / fx;
        b = ((longint'(cv) - cy) * 65536) / fy;
        if (a >= (64'sd1 <<< 24) || a <= -(64'sd1 <<< 24)
            || b >= (64'sd1 <<< 24) || b <= -(64'sd1 <<< 24))
            return rcd_pkg::DIST_MAX;
        x = rot_of(0, 0) * a + rot_of(0, 1) * b + rot_of(0, 2) * 65536;
        y = rot_of(1, 0) * a + rot_of(1, 1) * b + rot_of(1, 2) * 65536;
        z = rot_of(2, 0) * a + rot_of(2, 1) * b + rot_of(2, 2) * 65536;
        if (z <= 0)
            return rcd_pkg::DIST_MAX;
        du = longint'(ku) - cx - (fx * x) / z;
        dv = longint'(kv) - cy - (fy * y) / z;
        if (du >= (64'sd1 <<< 20) || du <= -(64'sd1 <<< 20)
            || dv >= (64'sd1 <<< 20) || dv <= -(64'sd1 <<< 20))
            return rcd_pkg::DIST_MAX;
        d = root_rounded(longint'(du * du + dv * dv));
        if (d > rcd_pkg::DIST_MAX)
            return rcd_pkg::DIST_MAX;
        sat = 1'b0;
        return d[rcd_pkg::DIST_W-1:0];
    endfunction

    function automatic void accumulate_pair(input logic [rcd_pkg::PIX_W-1:0] cu, cv, ku, kv,
                                            input logic last);
        bit sat;
        logic [rcd_pkg::DIST_W-1:0] d;
        longint unsigned n;
        longint unsigned m;
        set_result_t r;
        if (pairs_in_set < rcd_pkg::MAX_POINTS)
        begin
            d = pair_distance(cu, cv, ku, kv, sat);
            dist_sum = dist_sum + d;
            if (dist_sum > 64'hFFFF_FFFF)
                dist_sum = 64'hFFFF_FFFF;
            pairs_in_set++;
            if (sat)
                sat_in_set = 1'b1;
        end
        if (last)
        begin
            n = (pairs_in_set == 0) ? 1 : pairs_in_set;
            m = (dist_sum + n / 2) / n;
            r.mean = (m > rcd_pkg::DIST_MAX) ? rcd_pkg::DIST_MAX : m[rcd_pkg::DIST_W-1:0];
            r.count = pairs_in_set[rcd_pkg::CNT_W-1:0];
            r.sat = sat_in_set;
            set_results.insert(set_results.size(), r);
            dist_sum = 0;
            pairs_in_set = 0;
            sat_in_set = 1'b0;
        end
    endfunction

    task automatic send_pair(input logic [rcd_pkg::PIX_W-1:0] cu, cv, ku, kv,
                             input logic last);
        while (idle_on && $urandom_range(99) < 37)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.current_u  <= cu;
        in_ch.current_v  <= cv;
        in_ch.keyframe_u <= ku;
        in_ch.keyframe_v <= kv;
        in_ch.last_pair  <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        accumulate_pair(cu, cv, ku, kv, last);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input rcd_pkg::reg_index_t idx,
                             input logic [rcd_pkg::CFG_DW-1:0] value);
        in_ch.valid <= 1'b0;
        while (set_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rcd_pkg::REG_FOCAL:  focal_reg  = value[rcd_pkg::PAIR_W-1:0];
            rcd_pkg::REG_CENTER: center_reg = value[rcd_pkg::PAIR_W-1:0];
            rcd_pkg::REG_ROT0:   rot_reg[0] = value;
            rcd_pkg::REG_ROT1:   rot_reg[1] = value;
            default:             rot_reg[2] = value;
        endcase
    endtask

    function automatic logic [rcd_pkg::ROT_W-1:0] near(input int base);
        return rcd_pkg::ROT_W'(base + int'($urandom_range(1200)) - 600);
    endfunction

    task automatic camera_setup(input int kind);
        case (kind)
            0:
            begin
                write_reg(rcd_pkg::REG_FOCAL,
                          rcd_pkg::CFG_DW'({16'($urandom_range(16'h7000, 16'h1000)),
                                            16'($urandom_range(16'h7000, 16'h1000))}));
                write_reg(rcd_pkg::REG_CENTER,
                          rcd_pkg::CFG_DW'({16'($urandom_range(16'h3000, 16'h1000)),
                                            16'($urandom_range(16'h3000, 16'h1000))}));
                write_reg(rcd_pkg::REG_ROT0, {near(16384), near(0), near(0)});
                write_reg(rcd_pkg::REG_ROT1, {near(0), near(16384), near(0)});
                write_reg(rcd_pkg::REG_ROT2, {near(0), near(0), near(16384)});
            end
            1:
            begin
                write_reg(rcd_pkg::REG_FOCAL, rcd_pkg::CFG_DW'({$urandom, 16'hFFFF}));
                write_reg(rcd_pkg::REG_CENTER, '1);
                write_reg(rcd_pkg::REG_ROT0, '1);
                write_reg(rcd_pkg::REG_ROT1, rcd_pkg::CFG_DW'({$urandom, $urandom}));
                write_reg(rcd_pkg::REG_ROT2, {16'h0001, 16'h0000, 16'h7FFF});
            end
            default:
            begin
                write_reg(rcd_pkg::REG_FOCAL, rcd_pkg::CFG_DW'({$urandom, $urandom}));
                write_reg(rcd_pkg::REG_CENTER, rcd_pkg::CFG_DW'({$urandom, $urandom}));
                write_reg(rcd_pkg::REG_ROT0, rcd_pkg::CFG_DW'({$urandom, $urandom}));
                write_reg(rcd_pkg::REG_ROT1, rcd_pkg::CFG_DW'({$urandom, $urandom}));
                write_reg(rcd_pkg::REG_ROT2, rcd_pkg::CFG_DW'({$urandom, $urandom}));
            end
        endcase
    endtask

    task automatic random_set(input int len, input bit wild);
        logic [rcd_pkg::PIX_W-1:0] cu, cv, ku, kv;
        for (int i = 0; i < len; i++)
        begin
            if (wild || $urandom_range(9) == 0)
            begin
                cu = rcd_pkg::PIX_W'($urandom);
                cv = rcd_pkg::PIX_W'($urandom);
                ku = rcd_pkg::PIX_W'($urandom);
                kv = rcd_pkg::PIX_W'($urandom);
            end
            else
            begin
                cu = center_reg[31:16] + rcd_pkg::PIX_W'($urandom_range(4000))
                     - rcd_pkg::PIX_W'(2000);
                cv = center_reg[15:0] + rcd_pkg::PIX_W'($urandom_range(4000))
                     - rcd_pkg::PIX_W'(2000);
                ku = cu + rcd_pkg::PIX_W'($urandom_range(800)) - rcd_pkg::PIX_W'(400);
                kv = cv + rcd_pkg::PIX_W'($urandom_range(800)) - rcd_pkg::PIX_W'(400);
            end
            send_pair(cu, cv, ku, kv, i == len - 1);
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        hold_done = 1'b0;
        holdoff = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                holdoff = HOLD_CYCLES;
            end
            if (holdoff > 0)
            begin
                out_ch.ready <= 1'b0;
                holdoff--;
            end
            else
            begin
                out_ch.ready <= !(idle_on && $urandom_range(99) < 37);
            end
        end
    end

    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (set_results.size() == 0)
            begin
                report("unexpected result item", out_ch.mean_disparity, 0);
            end
            else
            begin
                want = set_results.pop_front();
                if (out_ch.mean_disparity !== want.mean)
                    report("mean_disparity", out_ch.mean_disparity, want.mean);
                if (out_ch.pair_count !== want.count)
                    report("pair_count", out_ch.pair_count, want.count);
                if (out_ch.any_saturated !== want.sat)
                    report("any_saturated", out_ch.any_saturated, want.sat);
                if (typed_results.size() != 0)
                begin
                    if (want !== typed_results[0])
                        report("typed result", want, typed_results[0]);
                    void'(typed_results.pop_front());
                end
                sets_done++;
                if (want.sat)
                    sat_sets++;
            end
        end
    end

    pair_row_t directed [] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{20'h0, 13'd1, 1'b0}},
        '{16'h0000, 16'h0000, 16'h0030, 16'h0040, 1'b1, 1'b1, '{20'h50, 13'd1, 1'b0}},
        '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{20'hFFFFF, 13'd1, 1'b1}},
        '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{20'hFFFFF, 13'd1, 1'b1}},
        '{16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 1'b1, 1'b1, '{20'h0, 13'd1, 1'b0}},
        '{16'h1000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{20'hFFFFF, 13'd1, 1'b1}},
        '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '{20'h0, 13'd0, 1'b0}},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '{20'h0, 13'd0, 1'b0}},
        '{16'h0123, 16'h0456, 16'h0789, 16'h0ABC, 1'b0, 1'b0, '{20'h0, 13'd0, 1'b0}},
        '{16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 1'b0, 1'b0, '{20'h0, 13'd0, 1'b0}},
        '{16'h0AAA, 16'h0555, 16'h5555, 16'hAAAA, 1'b1, 1'b0, '{20'h0, 13'd0, 1'b0}}
    };

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.current_u = '0;
        in_ch.current_v = '0;
        in_ch.keyframe_u = '0;
        in_ch.keyframe_v = '0;
        in_ch.last_pair = 1'b0;
        hold_req = 1'b0;
        idle_on = 1'b1;
        errors = 0;
        sets_done = 0;
        sat_sets = 0;
        pairs_sent = 0;
        focal_reg = rcd_pkg::FOCAL_RST;
        center_reg = rcd_pkg::CENTER_RST;
        rot_reg[0] = rcd_pkg::ROT0_RST;
        rot_reg[1] = rcd_pkg::ROT1_RST;
        rot_reg[2] = rcd_pkg::ROT2_RST;
        dist_sum = 0;
        pairs_in_set = 0;
        sat_in_set = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].typed)
                typed_results.insert(typed_results.size(), directed[i].res);
            send_pair(directed[i].cu, directed[i].cv, directed[i].ku, directed[i].kv,
                      directed[i].last);
        end

        write_reg(rcd_pkg::REG_FOCAL, rcd_pkg::CFG_DW'(32'h0000_0010));
        send_pair(16'h0010, 16'h0010, 16'h0000, 16'h0000, 1'b1);
        write_reg(rcd_pkg::REG_FOCAL, rcd_pkg::CFG_DW'(32'h0010_0010));
        write_reg(rcd_pkg::REG_ROT2, '0);
        send_pair(16'h0010, 16'h0010, 16'h0000, 16'h0000, 1'b1);
        write_reg(rcd_pkg::REG_ROT2, {16'h0000, 16'h0000, 16'h0001});
        write_reg(rcd_pkg::REG_ROT0, {16'h4000, 16'h0000, 16'h4000});
        send_pair(16'h0100, 16'h0100, 16'h0000, 16'h0000, 1'b1);
        write_reg(rcd_pkg::REG_ROT0, rcd_pkg::ROT0_RST);
        write_reg(rcd_pkg::REG_ROT2, rcd_pkg::ROT2_RST);

        for (int phase = 0; phase < 12; phase++)
        begin
            camera_setup(phase < 8 ? 0 : phase - 8);
            if (phase == 3)
                idle_on = 1'b0;
            if (phase == 5)
                idle_on = 1'b1;
            for (int s = 0; s < 17; s++)
            begin
                if (phase == 2 && s == 4)
                    hold_req = 1'b1;
                random_set($urandom_range(12, 1), phase >= 8 || $urandom_range(4) == 0);
            end
        end

        write_reg(rcd_pkg::REG_FOCAL, rcd_pkg::CFG_DW'(rcd_pkg::FOCAL_RST));
        random_set(3, 1'b0);
        in_ch.valid <= 1'b0;

        while (set_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        $display("%0d pairs in %0d sets checked, %0d sets with a saturated pair",
                 pairs_sent, sets_done, sat_sets);
        $display("covered zero focal, wide point, bad depth, long output stall and random rotations");
        if (errors == 0)
            $display("rotation_compensated_disparity_unit: match");
        else
            $display("rotation_compensated_disparity_unit: mismatch");
        $finish;
    end
endmodule
